FILE: rtl/core/include_directive_scanner_assert.svh
// Assertion macros used by the include directive scanner checker.
`ifndef INCLUDE_DIRECTIVE_SCANNER_ASSERT_SVH
`define INCLUDE_DIRECTIVE_SCANNER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define IDS_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define IDS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: rtl/core/ids_pkg.sv
// Shared types and character constants for the include directive scanner.
`timescale 1ns / 1ps
package ids_pkg;

	localparam logic [7:0] CH_HASH  = 8'h23;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_LT    = 8'h3C;
	localparam logic [7:0] CH_GT    = 8'h3E;
	localparam logic [7:0] CH_DOT   = 8'h2E;
	localparam logic [7:0] CH_NL    = 8'h0A;
	localparam logic [7:0] CH_I     = 8'h69;
	localparam logic [7:0] CH_N     = 8'h6E;
	localparam logic [7:0] CH_C     = 8'h63;
	localparam logic [7:0] CH_L     = 8'h6C;
	localparam logic [7:0] CH_U     = 8'h75;
	localparam logic [7:0] CH_D     = 8'h64;
	localparam logic [7:0] CH_E     = 8'h65;
	localparam logic [7:0] CH_H     = 8'h68;

	typedef enum logic [1:0] {
		STATUS_NAME = 2'd0,
		STATUS_BAD  = 2'd1,
		STATUS_LONG = 2'd2
	} status_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic    clear_store;
		logic    store;
		logic    start_emit;
		logic    read;
		logic    load_name;
		logic    load_err;
		status_t err_code;
	} dp_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic is_hash;
		logic is_i;
		logic is_n;
		logic is_c;
		logic is_l;
		logic is_u;
		logic is_d;
		logic is_e;
		logic is_space;
		logic is_lt;
		logic is_gt;
		logic is_dot;
		logic is_h;
		logic is_nl;
		logic full;
		logic last;
		logic out_free;
	} dp_stat_t;

endpackage

FILE: rtl/core/ids_datapath.sv
// Datapath of the include directive scanner: byte decode, name memory, output register.
`timescale 1ns / 1ps
module ids_datapath import ids_pkg::*; #(
	parameter int NAME_MAX = 64
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic [7:0] text_byte,
	input  dp_cmd_t    cmd,
	output dp_stat_t   stat,
	output logic       name_valid,
	input  logic       name_stall,
	output logic [7:0] name_byte,
	output logic       last_of_name,
	output logic [1:0] status
);

	localparam int AW = (NAME_MAX > 1) ? $clog2(NAME_MAX) : 1;
	localparam int LW = $clog2(NAME_MAX + 1);
	localparam logic [LW-1:0] LEN_FULL = LW'(NAME_MAX);

	logic [7:0]    mem [NAME_MAX];
	logic [LW-1:0] len_q;
	logic [LW-1:0] rd_idx_q;
	logic [7:0]    rd_data_q;
	logic          out_valid_q;
	logic [7:0]    out_byte_q;
	logic          out_last_q;
	status_t       out_status_q;
	logic          wr_en;
	logic [AW-1:0] wr_addr;

	always_comb begin
		stat.is_hash  = (text_byte == CH_HASH);
		stat.is_i     = (text_byte == CH_I);
		stat.is_n     = (text_byte == CH_N);
		stat.is_c     = (text_byte == CH_C);
		stat.is_l     = (text_byte == CH_L);
		stat.is_u     = (text_byte == CH_U);
		stat.is_d     = (text_byte == CH_D);
		stat.is_e     = (text_byte == CH_E);
		stat.is_space = (text_byte == CH_SPACE);
		stat.is_lt    = (text_byte == CH_LT);
		stat.is_gt    = (text_byte == CH_GT);
		stat.is_dot   = (text_byte == CH_DOT);
		stat.is_h     = (text_byte == CH_H);
		stat.is_nl    = (text_byte == CH_NL);
		stat.full     = (len_q == LEN_FULL);
		stat.last     = (rd_idx_q == len_q);
		stat.out_free = !out_valid_q || !name_stall;
	end

	// The opening bracket always lands at address zero.
	assign wr_en   = cmd.clear_store || cmd.store;
	assign wr_addr = cmd.clear_store ? '0 : len_q[AW-1:0];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= text_byte;
		end
		if (cmd.read) begin
			rd_data_q <= mem[rd_idx_q[AW-1:0]];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q    <= '0;
			rd_idx_q <= '0;
		end else begin
			if (cmd.clear_store) begin
				len_q <= LW'(1);
			end else if (cmd.store) begin
				len_q <= len_q + LW'(1);
			end
			if (cmd.start_emit) begin
				rd_idx_q <= '0;
			end else if (cmd.read) begin
				rd_idx_q <= rd_idx_q + LW'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_name || cmd.load_err) begin
			out_valid_q <= 1'b1;
		end else if (!name_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_name) begin
			out_byte_q   <= rd_data_q;
			out_last_q   <= stat.last;
			out_status_q <= STATUS_NAME;
		end else if (cmd.load_err) begin
			out_byte_q   <= 8'h00;
			out_last_q   <= 1'b1;
			out_status_q <= cmd.err_code;
		end
	end

	assign name_valid   = out_valid_q;
	assign name_byte    = out_byte_q;
	assign last_of_name = out_last_q;
	assign status       = out_status_q;

endmodule

FILE: rtl/core/ids_ctrl.sv
// Controller of the include directive scanner: match automaton and emission sequencing.
`timescale 1ns / 1ps
module ids_ctrl import ids_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     text_valid,
	output logic     text_stall,
	input  dp_stat_t stat,
	output dp_cmd_t  cmd
);

	typedef enum logic [16:0] {
		S_IDLE     = 17'h00001,
		S_HASH     = 17'h00002,
		S_I        = 17'h00004,
		S_N        = 17'h00008,
		S_C        = 17'h00010,
		S_L        = 17'h00020,
		S_U        = 17'h00040,
		S_D        = 17'h00080,
		S_E        = 17'h00100,
		S_SP       = 17'h00200,
		S_OPEN     = 17'h00400,
		S_DOT      = 17'h00800,
		S_H        = 17'h01000,
		S_EMIT_RD  = 17'h02000,
		S_EMIT_WR  = 17'h04000,
		S_ERR_BAD  = 17'h08000,
		S_ERR_LONG = 17'h10000
	} state_t;

	state_t state_q;
	state_t state_nxt;
	logic   stuck_q;
	logic   stuck_nxt;

	// Every state that looks at text_valid also drops text_stall, so a valid byte there
	// is an accepted byte.
	always_comb begin
		state_nxt  = state_q;
		stuck_nxt  = stuck_q;
		cmd        = '0;
		cmd.err_code = STATUS_NAME;
		text_stall = 1'b1;
		unique case (state_q)
			S_IDLE: begin
				// Once an error has been reported, every byte is dropped.
				text_stall = 1'b0;
				if (text_valid && !stuck_q && stat.is_hash) begin
					state_nxt = S_HASH;
				end
			end
			S_HASH: begin
				text_stall = 1'b0;
				if (text_valid) state_nxt = stat.is_i ? S_I : S_IDLE;
			end
			S_I: begin
				text_stall = 1'b0;
				if (text_valid) state_nxt = stat.is_n ? S_N : S_IDLE;
			end
			S_N: begin
				text_stall = 1'b0;
				if (text_valid) state_nxt = stat.is_c ? S_C : S_IDLE;
			end
			S_C: begin
				text_stall = 1'b0;
				if (text_valid) state_nxt = stat.is_l ? S_L : S_IDLE;
			end
			S_L: begin
				text_stall = 1'b0;
				if (text_valid) state_nxt = stat.is_u ? S_U : S_IDLE;
			end
			S_U: begin
				text_stall = 1'b0;
				if (text_valid) state_nxt = stat.is_d ? S_D : S_IDLE;
			end
			S_D: begin
				text_stall = 1'b0;
				if (text_valid) state_nxt = stat.is_e ? S_E : S_IDLE;
			end
			S_E: begin
				text_stall = 1'b0;
				if (text_valid) state_nxt = stat.is_space ? S_SP : S_IDLE;
			end
			S_SP: begin
				text_stall = 1'b0;
				if (text_valid) begin
					if (stat.is_lt) begin
						cmd.clear_store = 1'b1;
						state_nxt = S_OPEN;
					end else begin
						state_nxt = S_IDLE;
					end
				end
			end
			S_OPEN: begin
				text_stall = 1'b0;
				if (text_valid) begin
					priority if (stat.is_nl) begin
						state_nxt = S_ERR_BAD;
					end else if (stat.full) begin
						state_nxt = S_ERR_LONG;
					end else begin
						cmd.store = 1'b1;
						if (stat.is_dot) state_nxt = S_DOT;
					end
				end
			end
			S_DOT: begin
				text_stall = 1'b0;
				if (text_valid) begin
					priority if (!stat.is_h) begin
						state_nxt = S_ERR_BAD;
					end else if (stat.full) begin
						state_nxt = S_ERR_LONG;
					end else begin
						cmd.store = 1'b1;
						state_nxt = S_H;
					end
				end
			end
			S_H: begin
				text_stall = 1'b0;
				if (text_valid) begin
					priority if (!stat.is_gt) begin
						state_nxt = S_ERR_BAD;
					end else if (stat.full) begin
						state_nxt = S_ERR_LONG;
					end else begin
						cmd.store      = 1'b1;
						cmd.start_emit = 1'b1;
						state_nxt      = S_EMIT_RD;
					end
				end
			end
			S_EMIT_RD: begin
				cmd.read  = 1'b1;
				state_nxt = S_EMIT_WR;
			end
			S_EMIT_WR: begin
				if (stat.out_free) begin
					cmd.load_name = 1'b1;
					state_nxt = stat.last ? S_IDLE : S_EMIT_RD;
				end
			end
			S_ERR_BAD: begin
				if (stat.out_free) begin
					cmd.load_err = 1'b1;
					cmd.err_code = STATUS_BAD;
					stuck_nxt    = 1'b1;
					state_nxt    = S_IDLE;
				end
			end
			S_ERR_LONG: begin
				if (stat.out_free) begin
					cmd.load_err = 1'b1;
					cmd.err_code = STATUS_LONG;
					stuck_nxt    = 1'b1;
					state_nxt    = S_IDLE;
				end
			end
			default: begin
				state_nxt = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			stuck_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			stuck_q <= stuck_nxt;
		end
	end

endmodule

FILE: rtl/core/include_directive_scanner.sv
// Top level of the include directive scanner.
//
//  Channel  | Handshake          | Payload
//  ---------+--------------------+-----------------------------------------
//  text     | text_valid/stall   | text_byte
//  name     | name_valid/stall   | name_byte, last_of_name, status
//
// While scanning, one text byte is taken every cycle.
// A found name is sent out byte by byte, each byte first read through the single read port of the
// name memory into its registered read data; text is held off during that time.
// An error request waits for the output register, then all further text is dropped.
// Reset is asynchronous and needs no clearing pass; a stalled output holds its request.
`timescale 1ns / 1ps
module include_directive_scanner import ids_pkg::*; #(
	parameter int NAME_MAX = 64
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       text_valid,
	output logic       text_stall,
	input  logic [7:0] text_byte,
	output logic       name_valid,
	input  logic       name_stall,
	output logic [7:0] name_byte,
	output logic       last_of_name,
	output logic [1:0] status
);

	dp_cmd_t  cmd;
	dp_stat_t stat;

	ids_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.text_valid (text_valid),
		.text_stall (text_stall),
		.stat       (stat),
		.cmd        (cmd)
	);

	ids_datapath #(
		.NAME_MAX (NAME_MAX)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.text_byte    (text_byte),
		.cmd          (cmd),
		.stat         (stat),
		.name_valid   (name_valid),
		.name_stall   (name_stall),
		.name_byte    (name_byte),
		.last_of_name (last_of_name),
		.status       (status)
	);

endmodule

FILE: rtl/core/ids_checker.sv
// Port-level checker for the include directive scanner, bound to the top level.
`timescale 1ns / 1ps
`include "include_directive_scanner_assert.svh"
module ids_checker import ids_pkg::*; (
	input logic       clk,
	input logic       arst_n,
	input logic       name_valid,
	input logic       name_stall,
	input logic [7:0] name_byte,
	input logic       last_of_name,
	input logic [1:0] status
);

	`IDS_ASSERT_NEXT(a_hold_stalled, name_valid && name_stall, name_valid && $stable(name_byte) && $stable(last_of_name) && $stable(status), "stalled request changed")
	`IDS_ASSERT_NOW(a_err_form, name_valid && (status != STATUS_NAME), last_of_name && (name_byte == 8'h00), "error request not marked last with zero byte")
	`IDS_ASSERT_NEXT(a_silent_after_err, name_valid && !name_stall && (status != STATUS_NAME), !name_valid, "request after an error")
	`IDS_ASSERT_NOW(a_name_ends_gt, name_valid && (status == STATUS_NAME) && last_of_name, name_byte == CH_GT, "name does not end in a closing bracket")

endmodule

bind include_directive_scanner ids_checker u_ids_checker (.*);
